FILE: rtl/oale_pkg.sv
// Package for the ordered array list engine.
// Holds the operation and status codes, the default capacity and the cell control struct.
// No dependencies.
package oale_pkg;

    // Default number of list slots.
    localparam int DEF_CAPACITY = 128;

    // Width of one stored element.
    localparam int DATA_W = 32;

    // Operation codes carried by an input beat.
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_LOCATE = 3'd2,
        OP_GET    = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    // Status codes carried by a result beat.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Index reported when nothing was found.
    localparam logic [7:0] NO_INDEX = 8'hFF;

    // Broadcast control for the row of cells, already qualified by the accepted beat.
    typedef struct packed {
        logic ins;   // valid insert: shift up from pos, write value at pos
        logic del;   // valid delete: shift down from pos
        logic loc;   // locate: flag a matching live slot
        logic get;   // get: flag the slot to read
    } t_cell_ctl;

endpackage

FILE: rtl/oale_cell.sv
// One slot of the list: holds an element, shifts it to or from its neighbours and flags hits.
// Depends on oale_pkg.
module oale_cell #(
    parameter int IDX = 0,
    parameter int PW  = 8
) (
    input  logic                          i_clk,
    input  oale_pkg::t_cell_ctl           i_ctl,
    input  logic [PW-1:0]                 i_pos,
    input  logic [PW-1:0]                 i_cnt,
    input  logic [oale_pkg::DATA_W-1:0]   i_value,
    input  logic [oale_pkg::DATA_W-1:0]   i_left,
    input  logic [oale_pkg::DATA_W-1:0]   i_right,
    output logic [oale_pkg::DATA_W-1:0]   o_slot,
    output logic                          o_hit
);

    localparam logic [PW-1:0] ME = PW'(IDX);

    logic [oale_pkg::DATA_W-1:0] r_slot;
    logic [oale_pkg::DATA_W-1:0] n_slot;
    logic                        w_live;

    // A slot is live when it lies below the current length.
    assign w_live = ME < i_cnt;

    // Next slot content: written value, neighbour below or neighbour above.
    always_comb begin
        n_slot = r_slot;
        if (i_ctl.ins) begin
            if (ME == i_pos) begin
                n_slot = i_value;
            end else if ((ME > i_pos) && (ME <= i_cnt)) begin
                n_slot = i_left;
            end
        end else if (i_ctl.del) begin
            if ((ME >= i_pos) && ((ME + PW'(1)) < i_cnt)) begin
                n_slot = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    // Hit flag: a match for locate, or the slot to return for get.
    // An out-of-range get falls back to slot zero of a non-empty list.
    always_comb begin
        o_hit = 1'b0;
        if (i_ctl.loc) begin
            o_hit = w_live && (r_slot == i_value);
        end else if (i_ctl.get) begin
            o_hit = ((ME == i_pos) && (i_pos < i_cnt))
                 || ((ME == '0) && (i_pos >= i_cnt) && (i_cnt != '0));
        end
    end

    assign o_slot = r_slot;

endmodule

FILE: rtl/oale_find.sv
// Registered pairwise reduction that finds the lowest flagged slot and its element.
// One tree level per step; depends on oale_pkg.
module oale_find #(
    parameter int CAPACITY = oale_pkg::DEF_CAPACITY,
    parameter int IW       = $clog2(CAPACITY)
) (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic                          i_step,
    input  logic                          i_hit  [CAPACITY],
    input  logic [oale_pkg::DATA_W-1:0]   i_data [CAPACITY],
    output logic                          o_fnd,
    output logic [IW-1:0]                 o_idx,
    output logic [oale_pkg::DATA_W-1:0]   o_dat
);

    logic                        r_fnd [CAPACITY];
    logic [IW-1:0]               r_idx [CAPACITY];
    logic [oale_pkg::DATA_W-1:0] r_dat [CAPACITY];

    // Node k takes the better of nodes 2k and 2k+1; the lower index wins.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_node
        logic                        w_fnd;
        logic [IW-1:0]               w_idx;
        logic [oale_pkg::DATA_W-1:0] w_dat;

        if (2 * k + 1 < CAPACITY) begin : g_pair
            assign w_fnd = r_fnd[2*k] | r_fnd[2*k+1];
            assign w_idx = r_fnd[2*k] ? r_idx[2*k] : r_idx[2*k+1];
            assign w_dat = r_fnd[2*k] ? r_dat[2*k] : r_dat[2*k+1];
        end else if (2 * k < CAPACITY) begin : g_single
            assign w_fnd = r_fnd[2*k];
            assign w_idx = r_idx[2*k];
            assign w_dat = r_dat[2*k];
        end else begin : g_hold
            assign w_fnd = r_fnd[k];
            assign w_idx = r_idx[k];
            assign w_dat = r_dat[k];
        end

        always_ff @(posedge i_clk) begin
            if (i_load) begin
                r_fnd[k] <= i_hit[k];
                r_idx[k] <= IW'(k);
                r_dat[k] <= i_data[k];
            end else if (i_step) begin
                r_fnd[k] <= w_fnd;
                r_idx[k] <= w_idx;
                r_dat[k] <= w_dat;
            end
        end
    end

    assign o_fnd = r_fnd[0];
    assign o_idx = r_idx[0];
    assign o_dat = r_dat[0];

endmodule

FILE: rtl/ordered_array_list_engine_unit.sv
// Top level of the ordered array list engine: a row of slot cells, a find tree and control.
// Depends on oale_pkg, oale_cell and oale_find.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready | i_op, i_pos, i_value
//  out     | output    | o_out_valid/i_out_ready | o_data, o_index, o_status, o_length
//
// Insert, delete, clear and unused codes finish in the cycle of acceptance: every cell shifts
// at once and the result beat is registered at that edge, so one such beat a cycle while the
// output register is free or draining. Locate and get go through the find tree: the cells flag
// hits into the tree, which reduces one level per cycle before the result is registered.
// Reset clears the length, the control state and the output valid; slot contents are left.
// A result beat waits in the output register; a new beat is taken in the cycle it drains.
module ordered_array_list_engine_unit #(
    parameter int CAPACITY = oale_pkg::DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_op,
    input  logic [7:0]         i_pos,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_data,
    output logic signed [7:0]  o_index,
    output logic [1:0]         o_status,
    output logic [7:0]         o_length
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 8) ? CW : 8;
    localparam int XW = (IW > 8) ? IW : 8;
    localparam int SW = $clog2(IW + 1);
    localparam int DW = oale_pkg::DATA_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RED  = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [SW-1:0]       r_step;
    logic [2:0]          r_op;
    logic                r_badpos;
    logic                r_ov;
    logic [DW-1:0]       r_data;
    logic [7:0]          r_index;
    logic [1:0]          r_status;
    logic [7:0]          r_length;

    logic                w_acc;
    logic [PW-1:0]       w_pos, w_cnt;
    logic                w_full;
    logic                w_out_free;
    oale_pkg::t_cell_ctl w_ctl;
    logic                w_ld_now, w_ld_red;
    logic [1:0]          w_now_status;
    logic [PW-1:0]       w_len_now;
    logic [PW-1:0]       w_len_cur;
    logic [XW-1:0]       w_idx_wide;
    logic [1:0]          w_red_status;
    logic [DW-1:0]       w_red_data;
    logic [7:0]          w_red_index;

    logic                w_hit  [CAPACITY];
    logic [DW-1:0]       w_slot [CAPACITY];
    logic                w_fnd;
    logic [IW-1:0]       w_fidx;
    logic [DW-1:0]       w_fdat;

    // Input handshake: idle, and the output register free or draining.
    assign w_out_free = !r_ov || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_acc      = i_in_valid && o_in_ready;

    assign w_pos  = PW'(i_pos);
    assign w_cnt  = PW'(r_count);
    assign w_full = r_count == CW'(CAPACITY);

    // Decode the accepted beat into cell control, next length and immediate status.
    always_comb begin
        w_ctl        = '0;
        n_count      = r_count;
        w_now_status = oale_pkg::ST_OK;
        unique case (i_op)
            oale_pkg::OP_INSERT: begin
                if (w_full) begin
                    w_now_status = oale_pkg::ST_FULL;
                end else if (w_pos > w_cnt) begin
                    w_now_status = oale_pkg::ST_BADPOS;
                end else begin
                    w_ctl.ins = w_acc;
                    n_count   = r_count + CW'(1);
                end
            end
            oale_pkg::OP_DELETE: begin
                if (w_pos >= w_cnt) begin
                    w_now_status = oale_pkg::ST_BADPOS;
                end else begin
                    w_ctl.del = w_acc;
                    n_count   = r_count - CW'(1);
                end
            end
            oale_pkg::OP_LOCATE: w_ctl.loc = w_acc;
            oale_pkg::OP_GET:    w_ctl.get = w_acc;
            oale_pkg::OP_CLEAR:  n_count   = '0;
            default:             n_count   = r_count;
        endcase
    end

    // Row of slot cells, each linked to its two neighbours.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DW-1:0] w_left, w_right;

        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_slot[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_slot[i+1];
        end

        oale_cell #(
            .IDX (i),
            .PW  (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_pos),
            .i_cnt   (w_cnt),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_slot  (w_slot[i]),
            .o_hit   (w_hit[i])
        );
    end

    // Find tree: loaded with the hits of a locate or get, then reduced one level a cycle.
    oale_find #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_find (
        .i_clk  (i_clk),
        .i_load (w_ctl.loc || w_ctl.get),
        .i_step ((r_state == S_RED) && (r_step != '0)),
        .i_hit  (w_hit),
        .i_data (w_slot),
        .o_fnd  (w_fnd),
        .o_idx  (w_fidx),
        .o_dat  (w_fdat)
    );

    // Result of a locate or get once the tree is reduced.
    assign w_idx_wide = XW'(w_fidx);
    always_comb begin
        w_red_data   = '0;
        w_red_index  = oale_pkg::NO_INDEX;
        w_red_status = oale_pkg::ST_OK;
        if (r_op == oale_pkg::OP_LOCATE) begin
            if (w_fnd) begin
                w_red_index = w_idx_wide[7:0];
            end else begin
                w_red_status = oale_pkg::ST_NOTFOUND;
            end
        end else begin
            w_red_data = w_fnd ? w_fdat : '0;
            if (r_badpos) begin
                w_red_status = oale_pkg::ST_BADPOS;
            end
        end
    end

    assign w_ld_now  = w_acc && !(w_ctl.loc || w_ctl.get);
    assign w_ld_red  = (r_state == S_RED) && (r_step == '0) && w_out_free;
    assign w_len_now = PW'(n_count);
    assign w_len_cur = PW'(r_count);

    // Sequencer state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_ctl.loc || w_ctl.get) n_state = S_RED;
            S_RED:   if (w_ld_red) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                r_count <= n_count;
            end
            if (w_ctl.loc || w_ctl.get) begin
                r_step <= SW'(IW);
            end else if ((r_state == S_RED) && (r_step != '0)) begin
                r_step <= r_step - SW'(1);
            end
            if (w_ld_now || w_ld_red) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers: the held beat and the result beat.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op     <= i_op;
            r_badpos <= w_pos >= w_cnt;
        end
        if (w_ld_now) begin
            r_data   <= '0;
            r_index  <= oale_pkg::NO_INDEX;
            r_status <= w_now_status;
            r_length <= w_len_now[7:0];
        end else if (w_ld_red) begin
            r_data   <= w_red_data;
            r_index  <= w_red_index;
            r_status <= w_red_status;
            r_length <= w_len_cur[7:0];
        end
    end

    assign o_out_valid = r_ov;
    assign o_data      = r_data;
    assign o_index     = r_index;
    assign o_status    = r_status;
    assign o_length    = r_length;

    // The length never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list length above capacity");

    // No beat is taken while the find tree is busy.
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RED) |-> !o_in_ready)
        else $error("input taken during a search");

    // An accepted clear empties the list and reports a zero length.
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_op == oale_pkg::OP_CLEAR)) |=> (r_count == '0) && (o_length == 8'd0))
        else $error("clear left elements behind");

endmodule

FILE: tb/sv/ordered_array_list_engine_unit_tb.sv
// Self-checking testbench for the ordered array list engine: directed and random commands
// against an in-bench model of the list, with random idling on both channels.
// Depends on oale_pkg and ordered_array_list_engine_unit.
`timescale 1ns / 1ps

module ordered_array_list_engine_unit_tb;

    localparam int LIST_CAP    = oale_pkg::DEF_CAPACITY;
    localparam int RAND_CMDS   = 1800;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 20;

    // Operation codes that the block does not define.
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    typedef struct {
        logic [2:0]         op;
        logic [7:0]         pos;
        logic signed [31:0] value;
        bit                 pause;  // hold off until every result is back
    } t_list_cmd;

    typedef struct {
        logic signed [31:0] data;
        logic signed [7:0]  index;
        oale_pkg::t_status  status;
        logic [7:0]         length;
    } t_list_result;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [2:0]         i_op        = oale_pkg::OP_INSERT;
    logic [7:0]         i_pos       = '0;
    logic signed [31:0] i_value     = '0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [31:0] o_data;
    logic signed [7:0]  o_index;
    logic [1:0]         o_status;
    logic [7:0]         o_length;

    t_list_cmd          cmd_queue[$];
    t_list_result       list_result_q[$];
    t_list_cmd          cur_cmd;
    t_list_result       want;
    logic signed [31:0] list_mem[LIST_CAP];
    int unsigned        list_len = 0;
    int unsigned        gen_len  = 0;
    int unsigned        n_cmds   = 0;
    bit                 pause_next = 1'b0;
    int                 err_count  = 0;
    int                 cyc        = 0;
    logic               calm;

    logic signed [31:0] value_pool[8] = '{32'sd0, -32'sd1, 32'sd1, 32'sh7FFFFFFF,
                                          32'sh80000000, 32'sd42, -32'sd100, 32'sh5A5A5A5A};

    ordered_array_list_engine_unit #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_pos       (i_pos),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data      (o_data),
        .o_index     (o_index),
        .o_status    (o_status),
        .o_length    (o_length)
    );

    // Clock and the single reset at the start of the run.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // A window of cycles in which neither side idles.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end
    assign calm = (cyc >= 2500) && (cyc < 4000);

    task automatic flag_error(input string msg);
        $display("ERROR at cycle %0d: %s", cyc, msg);
        err_count++;
    endtask

    // Applies one command to the model list and returns the result it should give.
    function automatic t_list_result list_apply(input t_list_cmd c);
        t_list_result r;
        int unsigned  k;
        bit           hit;
        r.data   = '0;
        r.index  = oale_pkg::NO_INDEX;
        r.status = oale_pkg::ST_OK;
        hit      = 1'b0;
        case (c.op)
            oale_pkg::OP_INSERT: begin
                // A full list is reported before a position past the end.
                if (list_len >= LIST_CAP) begin
                    r.status = oale_pkg::ST_FULL;
                end else if (c.pos > list_len) begin
                    r.status = oale_pkg::ST_BADPOS;
                end else begin
                    for (k = list_len; k > c.pos; k--) list_mem[k] = list_mem[k - 1];
                    list_mem[c.pos] = c.value;
                    list_len++;
                end
            end
            oale_pkg::OP_DELETE: begin
                if (c.pos >= list_len) begin
                    r.status = oale_pkg::ST_BADPOS;
                end else begin
                    for (k = c.pos; k + 1 < list_len; k++) list_mem[k] = list_mem[k + 1];
                    list_len--;
                end
            end
            oale_pkg::OP_LOCATE: begin
                // Only live entries are searched; the lowest match wins.
                r.status = oale_pkg::ST_NOTFOUND;
                for (k = 0; k < list_len; k++) begin
                    if (!hit && list_mem[k] == c.value) begin
                        hit      = 1'b1;
                        r.index  = k[7:0];
                        r.status = oale_pkg::ST_OK;
                    end
                end
            end
            oale_pkg::OP_GET: begin
                // Out of range reads return the first element, or zero on an empty list.
                if (c.pos < list_len) begin
                    r.data = list_mem[c.pos];
                end else begin
                    r.status = oale_pkg::ST_BADPOS;
                    r.data   = (list_len > 0) ? list_mem[0] : '0;
                end
            end
            oale_pkg::OP_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        r.length = list_len[7:0];
        return r;
    endfunction

    // Queues one command and follows the length that it will leave behind.
    task automatic queue_cmd(input logic [2:0] op, input int unsigned pos,
                             input logic signed [31:0] value);
        t_list_cmd c;
        c.op    = op;
        c.pos   = pos[7:0];
        c.value = value;
        c.pause = pause_next;
        pause_next = 1'b0;
        cmd_queue.push_back(c);
        n_cmds++;
        case (op)
            oale_pkg::OP_INSERT: if (gen_len < LIST_CAP && pos <= gen_len) gen_len++;
            oale_pkg::OP_DELETE: if (pos < gen_len) gen_len--;
            oale_pkg::OP_CLEAR:  gen_len = 0;
            default: begin
            end
        endcase
    endtask

    // Values are mostly drawn from a small pool so that searches find duplicates.
    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(3))
            0:       return $urandom;
            3:       return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return value_pool[3'($urandom_range(7))];
        endcase
    endfunction

    function automatic int unsigned rand_pos();
        if ($urandom_range(99) < 15) return $urandom_range(LIST_CAP);
        return $urandom_range(gen_len);
    endfunction

    function automatic logic [2:0] rand_op();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) return oale_pkg::OP_INSERT;
        if (r < 50) return oale_pkg::OP_DELETE;
        if (r < 70) return oale_pkg::OP_LOCATE;
        if (r < 92) return oale_pkg::OP_GET;
        if (r < 94) return oale_pkg::OP_CLEAR;
        return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    endfunction

    // Input driver: a beat stays on the bus until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                list_result_q.push_back(list_apply(cur_cmd));
            end
            if (!i_in_valid || o_in_ready) begin
                if (cmd_queue.size() > 0 && (calm || $urandom_range(99) >= 13) &&
                    !(cmd_queue[0].pause && list_result_q.size() > 0)) begin
                    cur_cmd = cmd_queue.pop_front();
                    i_op       <= cur_cmd.op;
                    i_pos      <= cur_cmd.pos;
                    i_value    <= cur_cmd.value;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: each result beat is checked against the oldest expected result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (list_result_q.size() == 0) begin
                    flag_error("result beat with no command outstanding");
                end else begin
                    want = list_result_q.pop_front();
                    if (o_data !== want.data)
                        flag_error($sformatf("data %0d, expected %0d", o_data, want.data));
                    if (o_index !== want.index)
                        flag_error($sformatf("index %0d, expected %0d", o_index, want.index));
                    if (o_status !== want.status)
                        flag_error($sformatf("status %0d, expected %0d", o_status, want.status));
                    if (o_length !== want.length)
                        flag_error($sformatf("length %0d, expected %0d", o_length, want.length));
                end
            end
            i_out_ready <= calm || ($urandom_range(99) >= 13);
        end
    end

    // Watchdog: ends the run if neither channel moves a beat for too long.
    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stall = 0;
            else stall++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus and end of run.
    initial begin
        int unsigned kind;

        // Directed: empty list, boundaries, duplicates, extremes and unused codes.
        queue_cmd(oale_pkg::OP_GET,    0, 32'sd0);
        queue_cmd(oale_pkg::OP_DELETE, 0, 32'sd0);
        queue_cmd(oale_pkg::OP_LOCATE, 0, 32'sd0);
        queue_cmd(oale_pkg::OP_INSERT, 1, 32'sd5);
        queue_cmd(oale_pkg::OP_INSERT, 0, 32'sh7FFFFFFF);
        queue_cmd(oale_pkg::OP_INSERT, 1, 32'sh80000000);
        queue_cmd(oale_pkg::OP_INSERT, 0, 32'sd0);
        queue_cmd(oale_pkg::OP_INSERT, 2, -32'sd1);
        queue_cmd(oale_pkg::OP_INSERT, 1, -32'sd1);
        queue_cmd(oale_pkg::OP_LOCATE, 0, -32'sd1);
        queue_cmd(oale_pkg::OP_LOCATE, 0, 32'sh80000000);
        queue_cmd(oale_pkg::OP_LOCATE, 0, 32'sd12345);
        queue_cmd(oale_pkg::OP_GET,    4, 32'sd0);
        queue_cmd(oale_pkg::OP_GET,    5, 32'sd0);
        queue_cmd(oale_pkg::OP_GET,    LIST_CAP, 32'sd0);
        queue_cmd(oale_pkg::OP_INSERT, LIST_CAP, 32'sd7);
        queue_cmd(oale_pkg::OP_DELETE, 2, 32'sd0);
        queue_cmd(oale_pkg::OP_DELETE, 4, 32'sd0);
        queue_cmd(oale_pkg::OP_DELETE, LIST_CAP, 32'sd0);
        queue_cmd(OP_SPARE_LO,  0, 32'sd1);
        queue_cmd(OP_SPARE_MID, 127, -32'sd1);
        queue_cmd(OP_SPARE_HI,  LIST_CAP, 32'sh80000000);
        queue_cmd(oale_pkg::OP_CLEAR,  0, 32'sd0);
        queue_cmd(oale_pkg::OP_GET,    0, 32'sd0);
        queue_cmd(oale_pkg::OP_LOCATE, 0, 32'sd0);

        // Random part in episodes; the first one waits for the directed results.
        pause_next = 1'b1;
        while (n_cmds < RAND_CMDS + 25) begin
            kind = $urandom_range(9);
            if ($urandom_range(7) == 0) pause_next = 1'b1;
            if (kind <= 1) begin
                // Fill to capacity with lookups mixed in, then push against the top.
                while (gen_len < LIST_CAP) begin
                    if ($urandom_range(3) == 0)
                        queue_cmd($urandom_range(1) ? oale_pkg::OP_LOCATE : oale_pkg::OP_GET,
                                  rand_pos(), rand_value());
                    else
                        queue_cmd(oale_pkg::OP_INSERT, $urandom_range(gen_len), rand_value());
                end
                repeat (4) queue_cmd(oale_pkg::OP_INSERT, $urandom_range(LIST_CAP),
                                     rand_value());
                repeat (4) queue_cmd(oale_pkg::OP_LOCATE, 0, rand_value());
            end else if (kind == 2) begin
                // Drain most of the list through valid deletes.
                while (gen_len > 2) begin
                    if ($urandom_range(4) == 0)
                        queue_cmd(oale_pkg::OP_GET, rand_pos(), rand_value());
                    else
                        queue_cmd(oale_pkg::OP_DELETE, $urandom_range(gen_len - 1),
                                  rand_value());
                end
            end else if (kind == 3) begin
                queue_cmd(oale_pkg::OP_CLEAR, rand_pos(), rand_value());
                repeat (5) queue_cmd(rand_op(), rand_pos(), rand_value());
            end else begin
                repeat (30) queue_cmd(rand_op(), rand_pos(), rand_value());
            end
        end

        while (cmd_queue.size() > 0 || i_in_valid) @(posedge i_clk);
        while (list_result_q.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
